### design/emtr_pkg.sv
`timescale 1ns / 1ps
package emtr_pkg;
  localparam int EpochW = 32;
  localparam int VtecW = 24;
  localparam int RaW = 25;
  localparam int DecW = 24;
  localparam int SumW = 40;
  localparam int CountW = 16;
  localparam int RankW = 5;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic OpSample = 1'b0;
  localparam logic OpEnd = 1'b1;

  typedef struct packed {
    logic [VtecW-1:0] vtec;
    logic [RaW-1:0] ra;
    logic [DecW-1:0] dec;
  } entry_t;

  // insertion and clear request broadcast along the chain
  typedef struct packed {
    logic   ins;
    logic   clear;
    entry_t data;
  } cell_ctl_t;
endpackage

### design/emtr_cell.sv
`timescale 1ns / 1ps
module emtr_cell (
  input  logic               clk,
  input  logic               rst,
  input  emtr_pkg::cell_ctl_t ctl,
  input  logic               shift,
  input  emtr_pkg::entry_t   prev_entry,
  input  logic               prev_valid,
  input  logic               prev_ge,
  output emtr_pkg::entry_t   entry,
  output logic               valid,
  output logic               ge
);
  import emtr_pkg::*;

  // this entry ranks above (or ties before) the new sample
  assign ge = valid && (entry.vtec >= ctl.data.vtec);

  // pop shift moves each entry one place toward rank 0
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid;
      entry <= prev_entry;
    end else if (ctl.ins && !ge) begin
      valid <= prev_ge || prev_valid;
      entry <= prev_ge ? ctl.data : prev_entry;
    end
  end
endmodule

### design/emtr_divider.sv
`timescale 1ns / 1ps
module emtr_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [emtr_pkg::SumW-1:0]   num,
  input  logic [emtr_pkg::CountW-1:0] den,
  output logic                        done,
  output logic [emtr_pkg::VtecW-1:0]  quot
);
  import emtr_pkg::*;

  logic [SumW-1:0] q;
  logic [CountW:0] r;
  logic [5:0] cnt;
  logic busy;
  logic [CountW:0] r_sh;
  logic [CountW:0] r_sub;

  assign r_sh = {r[CountW-1:0], q[SumW-1]};
  assign r_sub = r_sh - {1'b0, den};
  assign quot = q[VtecW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q <= num;
        r <= '0;
        cnt <= 6'(SumW);
      end else if (busy) begin
        if (!r_sub[CountW]) begin
          r <= r_sub;
          q <= {q[SumW-2:0], 1'b1};
        end else begin
          r <= r_sh;
          q <= {q[SumW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### design/epoch_mean_topk_ranker.sv
`timescale 1ns / 1ps
// channel  | direction | handshake     | fields
// in       | input     | valid, stall  | opcode epoch vtec ra dec
// out      | output    | out_valid, out_stall | closed_epoch .. best_mean_vtec
// A sample inside an epoch is compared across the cell chain, then inserted (S_INS).
// An end word holds the input while the bit-serial 40-bit mean divider runs, then while
// each kept word is emitted in rank order and the chain drains before return to idle.
// A new epoch sample also closes the open epoch, then inserts into the emptied chain.
// Reset (rst, synchronous) clears all control state; kept entries need no clearing.
// out_stall holds the result register; input is stalled during insert, close and emission.
module epoch_mean_topk_ranker #(
  parameter int TOP_COUNT = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic stall,
  input  logic opcode,
  input  logic [emtr_pkg::EpochW-1:0] epoch,
  input  logic [emtr_pkg::VtecW-1:0] vtec,
  input  logic [emtr_pkg::RaW-1:0] ra,
  input  logic signed [emtr_pkg::DecW-1:0] dec,
  output logic out_valid,
  input  logic out_stall,
  output logic [emtr_pkg::EpochW-1:0] closed_epoch,
  output logic [emtr_pkg::VtecW-1:0] mean_vtec,
  output logic [emtr_pkg::CountW-1:0] sample_count,
  output logic [emtr_pkg::RankW-1:0] rank,
  output logic [emtr_pkg::VtecW-1:0] kept_vtec,
  output logic [emtr_pkg::RaW-1:0] kept_ra,
  output logic signed [emtr_pkg::DecW-1:0] kept_dec,
  output logic last,
  output logic [emtr_pkg::EpochW-1:0] best_epoch,
  output logic [emtr_pkg::VtecW-1:0] best_mean_vtec
);
  import emtr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_INS, S_DIV, S_WAIT, S_EMIT} state_t;
  state_t state;

  logic open_flag;
  logic [EpochW-1:0] current_epoch;
  logic [SumW-1:0] vtec_sum;
  logic [CountW-1:0] count_in_epoch;
  logic best_valid;
  logic [EpochW-1:0] best_epoch_reg;
  logic [VtecW-1:0] best_mean_reg;
  logic [VtecW-1:0] mean;
  logic [RankW-1:0] emit_rank;
  logic pend_open;
  entry_t pend;
  logic [EpochW-1:0] pend_epoch;

  cell_ctl_t ctl;
  logic shift;
  entry_t cell_entry [TOP_COUNT];
  logic cell_valid [TOP_COUNT];
  logic cell_ge [TOP_COUNT];

  logic div_start, div_done;
  logic [VtecW-1:0] div_q;

  assign ctl = '{ins: (state == S_INS),
                 clear: (state == S_IDLE) && valid && !stall && opcode == OpSample &&
                        (!open_flag || epoch != current_epoch) && !open_flag,
                 data: pend};
  assign shift = (state == S_EMIT) && (!out_valid || !out_stall) && cell_valid[0];

  for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
    entry_t pe;
    logic pv, pg;
    if (i == 0) begin : g_head
      assign pe = pend;
      assign pv = 1'b0;
      assign pg = 1'b1;
    end else begin : g_body
      assign pe = cell_entry[i-1];
      assign pv = cell_valid[i-1];
      assign pg = cell_ge[i-1];
    end
    entry_t sh_e;
    logic sh_v;
    if (i == TOP_COUNT - 1) begin : g_tail
      assign sh_e = cell_entry[i];
      assign sh_v = 1'b0;
    end else begin : g_mid
      assign sh_e = cell_entry[i+1];
      assign sh_v = cell_valid[i+1];
    end
    emtr_cell u_cell (
      .clk(clk), .rst(rst), .ctl(ctl),
      .shift(shift),
      .prev_entry(shift ? sh_e : pe),
      .prev_valid(shift ? sh_v : pv),
      .prev_ge(pg),
      .entry(cell_entry[i]),
      .valid(cell_valid[i]),
      .ge(cell_ge[i])
    );
  end

  emtr_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(vtec_sum), .den(count_in_epoch),
    .done(div_done), .quot(div_q)
  );

  assign stall = (state != S_IDLE);
  assign div_start = (state == S_IDLE) && valid && open_flag &&
                     (opcode == OpEnd || epoch != current_epoch);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      open_flag <= 1'b0;
      current_epoch <= '0;
      vtec_sum <= '0;
      count_in_epoch <= '0;
      best_valid <= 1'b0;
      best_epoch_reg <= '0;
      best_mean_reg <= '0;
      out_valid <= 1'b0;
      pend_open <= 1'b0;
      emit_rank <= '0;
    end else begin
      case (state)
        S_IDLE: if (valid) begin
          pend <= '{vtec: vtec, ra: ra, dec: dec};
          pend_epoch <= epoch;
          if (div_start) begin
            pend_open <= (opcode == OpSample);
            state <= S_DIV;
          end else if (opcode == OpSample) begin
            if (!open_flag) begin
              open_flag <= 1'b1;
              current_epoch <= epoch;
              vtec_sum <= SumW'(vtec);
              count_in_epoch <= CountW'(1);
            end else if (count_in_epoch != CountMax) begin
              vtec_sum <= vtec_sum + SumW'(vtec);
              count_in_epoch <= count_in_epoch + CountW'(1);
            end
            state <= S_INS;
          end
        end
        S_INS: state <= S_IDLE;
        S_DIV: if (div_done) begin
          mean <= div_q;
          if (!best_valid || div_q > best_mean_reg) begin
            best_valid <= 1'b1;
            best_epoch_reg <= current_epoch;
            best_mean_reg <= div_q;
          end
          emit_rank <= '0;
          state <= S_EMIT;
        end
        S_EMIT: if (!out_valid || !out_stall) begin
          if (cell_valid[0]) begin
            out_valid <= 1'b1;
            closed_epoch <= current_epoch;
            mean_vtec <= mean;
            sample_count <= count_in_epoch;
            rank <= emit_rank;
            kept_vtec <= cell_entry[0].vtec;
            kept_ra <= cell_entry[0].ra;
            kept_dec <= cell_entry[0].dec;
            last <= (TOP_COUNT == 1) ? 1'b1 : !cell_valid[1 % TOP_COUNT];
            best_epoch <= best_epoch_reg;
            best_mean_vtec <= best_mean_reg;
            emit_rank <= emit_rank + RankW'(1);
          end else begin
            out_valid <= 1'b0;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          // chain is empty; reopen with the held sample, or close the epoch after an end word
          if (pend_open) begin
            open_flag <= 1'b1;
            current_epoch <= pend_epoch;
            vtec_sum <= SumW'(pend.vtec);
            count_in_epoch <= CountW'(1);
            state <= S_INS;
          end else begin
            open_flag <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### design/emtr_checker.sv
`timescale 1ns / 1ps
module emtr_assertions (
  input logic clk,
  input logic rst,
  input logic valid,
  input logic stall,
  input logic out_valid,
  input logic out_stall,
  input logic last,
  input logic [4:0] rank,
  input logic [31:0] closed_epoch
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rank)) else $error("out word dropped");
  a_rank: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> !out_valid || rank != 5'd0) else $error("rank reset");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stall) else $error("input open during emission");
  a_ep: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last ##1 out_valid |-> $stable(closed_epoch))
    else $error("epoch changed within run");
endmodule

bind epoch_mean_topk_ranker emtr_assertions u_chk (
  .clk(clk), .rst(rst), .valid(valid), .stall(stall),
  .out_valid(out_valid), .out_stall(out_stall), .last(last),
  .rank(rank), .closed_epoch(closed_epoch)
);

### test/emtr_checker.sv
`timescale 1ns / 1ps
module emtr_checker #(
  parameter int TOP_COUNT = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  input  logic stall,
  input  logic opcode,
  input  logic [emtr_pkg::EpochW-1:0] epoch,
  input  logic [emtr_pkg::VtecW-1:0] vtec,
  input  logic [emtr_pkg::RaW-1:0] ra,
  input  logic signed [emtr_pkg::DecW-1:0] dec,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [emtr_pkg::EpochW-1:0] closed_epoch,
  input  logic [emtr_pkg::VtecW-1:0] mean_vtec,
  input  logic [emtr_pkg::CountW-1:0] sample_count,
  input  logic [emtr_pkg::RankW-1:0] rank,
  input  logic [emtr_pkg::VtecW-1:0] kept_vtec,
  input  logic [emtr_pkg::RaW-1:0] kept_ra,
  input  logic signed [emtr_pkg::DecW-1:0] kept_dec,
  input  logic last,
  input  logic [emtr_pkg::EpochW-1:0] best_epoch,
  input  logic [emtr_pkg::VtecW-1:0] best_mean_vtec,
  output int errors,
  output int pending,
  output int ranked_seen
);
  import emtr_pkg::*;

  typedef struct {
    logic [EpochW-1:0] epoch;
    logic [VtecW-1:0] mean;
    logic [CountW-1:0] count;
    logic [RankW-1:0] rank;
    entry_t entry;
    logic last;
    logic [EpochW-1:0] best_epoch;
    logic [VtecW-1:0] best_mean;
  } ranked_t;

  ranked_t ranked_q[$];

  logic epoch_open;
  logic [EpochW-1:0] open_epoch;
  logic [SumW-1:0] vtec_total;
  logic [CountW-1:0] vtec_count;
  entry_t top_list[TOP_COUNT];
  int top_used;
  logic have_best;
  logic [EpochW-1:0] best_ep;
  logic [VtecW-1:0] best_mn;

  assign pending = ranked_q.size();

  task automatic field_check(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic accumulate(entry_t s);
    int pos;
    int i;
    pos = 0;
    if (vtec_count != CountMax) begin
      vtec_total += s.vtec;
      vtec_count++;
    end
    while (pos < top_used && top_list[pos].vtec >= s.vtec) pos++;
    if (pos < TOP_COUNT) begin
      i = (top_used < TOP_COUNT) ? top_used : TOP_COUNT - 1;
      for (; i > pos; i--) top_list[i] = top_list[i-1];
      top_list[pos] = s;
      if (top_used < TOP_COUNT) top_used++;
    end
  endtask

  task automatic close_and_rank();
    logic [VtecW-1:0] avg;
    ranked_t r;
    avg = VtecW'(vtec_total / vtec_count);
    if (!have_best || avg > best_mn) begin
      have_best = 1'b1;
      best_ep = open_epoch;
      best_mn = avg;
    end
    for (int k = 0; k < top_used; k++) begin
      r.epoch = open_epoch;
      r.mean = avg;
      r.count = vtec_count;
      r.rank = RankW'(k);
      r.entry = top_list[k];
      r.last = (k + 1 == top_used);
      r.best_epoch = best_ep;
      r.best_mean = best_mn;
      ranked_q.push_back(r);
    end
    epoch_open = 1'b0;
  endtask

  task automatic open_new(logic [EpochW-1:0] e, entry_t s);
    epoch_open = 1'b1;
    open_epoch = e;
    vtec_total = '0;
    vtec_count = '0;
    top_used = 0;
    accumulate(s);
  endtask

  always @(posedge clk) begin : watch
    ranked_t want;
    entry_t s;
    if (rst) begin
      epoch_open = 1'b0;
      open_epoch = '0;
      vtec_total = '0;
      vtec_count = '0;
      top_used = 0;
      have_best = 1'b0;
      best_ep = '0;
      best_mn = '0;
      errors = 0;
      ranked_seen = 0;
      ranked_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        ranked_seen++;
        if (ranked_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, epoch 0x%0h rank %0d", $time,
                   closed_epoch, rank);
        end else begin
          want = ranked_q.pop_front();
          field_check("closed_epoch", want.epoch, closed_epoch);
          field_check("mean_vtec", want.mean, mean_vtec);
          field_check("sample_count", want.count, sample_count);
          field_check("rank", want.rank, rank);
          field_check("kept_vtec", want.entry.vtec, kept_vtec);
          field_check("kept_ra", want.entry.ra, kept_ra);
          field_check("kept_dec", want.entry.dec, $unsigned(kept_dec));
          field_check("last", want.last, last);
          field_check("best_epoch", want.best_epoch, best_epoch);
          field_check("best_mean_vtec", want.best_mean, best_mean_vtec);
        end
      end
      if (valid && !stall) begin
        s.vtec = vtec;
        s.ra = ra;
        s.dec = dec;
        if (opcode == OpEnd) begin
          if (epoch_open) close_and_rank();
        end else if (!epoch_open) begin
          open_new(epoch, s);
        end else if (epoch != open_epoch) begin
          close_and_rank();
          open_new(epoch, s);
        end else begin
          accumulate(s);
        end
      end
    end
  end
endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
  import emtr_pkg::*;

  localparam int TopN = 10;
  localparam int RaMax = 23592960;
  localparam int DecMax = 5898240;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic stall;
  logic opcode = OpSample;
  logic [EpochW-1:0] epoch = '0;
  logic [VtecW-1:0] vtec = '0;
  logic [RaW-1:0] ra = '0;
  logic signed [DecW-1:0] dec = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [EpochW-1:0] closed_epoch;
  logic [VtecW-1:0] mean_vtec;
  logic [CountW-1:0] sample_count;
  logic [RankW-1:0] rank;
  logic [VtecW-1:0] kept_vtec;
  logic [RaW-1:0] kept_ra;
  logic signed [DecW-1:0] kept_dec;
  logic last;
  logic [EpochW-1:0] best_epoch;
  logic [VtecW-1:0] best_mean_vtec;

  int errors;
  int pending;
  int ranked_seen;
  int sent;
  int idle_pct = 0;
  int stall_pct = 0;

  always #2 clk = ~clk;

  epoch_mean_topk_ranker #(.TOP_COUNT(TopN)) u_dut (.*);

  emtr_checker #(.TOP_COUNT(TopN)) u_check (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send(logic op, logic [EpochW-1:0] e, logic [VtecW-1:0] v,
                      logic [RaW-1:0] r, logic signed [DecW-1:0] d);
    if ($urandom_range(99) < idle_pct) begin
      valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    valid <= 1'b1;
    opcode <= op;
    epoch <= e;
    vtec <= v;
    ra <= r;
    dec <= d;
    @(posedge clk);
    while (stall) @(posedge clk);
    sent++;
  endtask

  task automatic sample(logic [EpochW-1:0] e, logic [VtecW-1:0] v);
    send(OpSample, e, v, RaW'($urandom_range(RaMax)),
         DecW'(int'($urandom_range(2 * DecMax)) - DecMax));
  endtask

  task automatic close_stream();
    send(OpEnd, EpochW'($urandom), VtecW'($urandom), RaW'($urandom), DecW'($urandom));
  endtask

  // grouped epochs with random content, some ties, long groups and stray ends
  task automatic random_epochs(int n);
    int stop;
    int group;
    logic [EpochW-1:0] e;
    logic [VtecW-1:0] base;
    stop = sent + n;
    e = $urandom;
    while (sent < stop) begin
      group = ($urandom_range(3) == 0) ? $urandom_range(11, 16) : $urandom_range(1, 8);
      base = VtecW'($urandom);
      for (int i = 0; i < group; i++) begin
        case ($urandom_range(9))
          0, 1: sample(e, base);
          2: sample(e, VtecW'($urandom_range(3)));
          3: sample(e, '1);
          default: sample(e, VtecW'($urandom));
        endcase
      end
      case ($urandom_range(9))
        0: close_stream();
        1: begin
          close_stream();
          close_stream();
        end
        2: close_stream();
        default: ;
      endcase
      e = ($urandom_range(4) == 0) ? EpochW'($urandom) : e + $urandom_range(1, 30);
    end
  endtask

  initial begin
    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing open: end does nothing
    close_stream();
    send(OpSample, '0, '0, '0, '0);
    send(OpSample, '1, '1, RaW'(RaMax), DecW'(DecMax));
    send(OpSample, '1, '1, '0, DecW'(-DecMax));
    send(OpSample, '1, 24'd5, RaW'(RaMax), DecW'(-1));
    // ties: earlier sample ranks first
    for (int i = 0; i < 12; i++)
      send(OpSample, 32'd7, 24'd100 + 24'(i % 3), RaW'(i), DecW'(-i));
    // full list: equal to the smallest does not enter
    send(OpSample, 32'd7, 24'd100, RaW'(99), DecW'(99));
    close_stream();
    close_stream();
    // a higher mean takes over the best epoch; a lower mean leaves it alone
    send(OpSample, 32'd7, '1, '0, '0);
    send(OpSample, 32'd8, 24'd3, '0, '0);
    close_stream();

    idle_pct = 0;
    stall_pct = 0;
    random_epochs(85);
    idle_pct = 45;
    random_epochs(85);
    idle_pct = 0;
    stall_pct = 45;
    random_epochs(85);
    idle_pct = 28;
    stall_pct = 28;
    random_epochs(85);
    close_stream();
    valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d input words and %0d ranked result words", sent, ranked_seen);
    $display("phases: directed edge cases, then four idle/stall mixes of grouped epochs");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout");
    $display("tb NOT OK");
    $finish;
  end
endmodule
